/* rtl/core/ellipse_vertex_generator_assert.svh */
// Assertion macros for the ellipse vertex generator.
`ifndef ELLIPSE_VERTEX_GENERATOR_ASSERT_SVH
`define ELLIPSE_VERTEX_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define EVG_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EVG_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EVG_ASSERT_IMPL(label, clk, rst, prop, msg)
`define EVG_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/core/evg_pkg.sv */
package evg_pkg;
  localparam int MaxSegments = 4096;
  localparam int CordicStages = 16;
  localparam int SegW = 13;
  localparam int CordW = 34;
  localparam int AngW = 33;
  localparam int QuoW = 45;
  localparam int DivSteps = 45;
  localparam logic [CordW-1:0] InvGain = CordW'(652032874);

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_SCALE_X = 3'd1;
  localparam logic [2:0] REG_SCALE_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_SEGMENTS = 3'd5;
  localparam logic [2:0] REG_COLOR = 3'd6;

  typedef struct packed {
    logic last;
    logic [31:0] color;
    logic [15:0] radius;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
  } side_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] r;
    case (k)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      default: r = 32'd81;
    endcase
    return r;
  endfunction
endpackage

/* rtl/core/evg_div_cell.sv */
module evg_div_cell (
  input  logic clk,
  input  logic en,
  input  logic [evg_pkg::QuoW-1:0] num_in,
  input  logic [evg_pkg::SegW:0] rem_in,
  input  logic [evg_pkg::SegW-1:0] seg_in,
  input  evg_pkg::side_t side_in,
  output logic [evg_pkg::QuoW-1:0] num_out,
  output logic [evg_pkg::SegW:0] rem_out,
  output logic [evg_pkg::SegW-1:0] seg_out,
  output evg_pkg::side_t side_out
);
  import evg_pkg::*;
  logic [SegW+1:0] trial;
  logic [SegW+1:0] diff;
  always_comb begin
    trial = {rem_in, num_in[QuoW-1]};
    diff = trial - {2'b0, seg_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!diff[SegW+1]) begin
        rem_out <= diff[SegW:0];
        num_out <= {num_in[QuoW-2:0], 1'b1};
      end else begin
        rem_out <= trial[SegW:0];
        num_out <= {num_in[QuoW-2:0], 1'b0};
      end
      seg_out <= seg_in;
      side_out <= side_in;
    end
  end
endmodule

/* rtl/core/evg_cordic_cell.sv */
module evg_cordic_cell (
  input  logic clk,
  input  logic en,
  input  logic [4:0] stage,
  input  logic signed [evg_pkg::CordW-1:0] x_in,
  input  logic signed [evg_pkg::CordW-1:0] y_in,
  input  logic signed [evg_pkg::AngW-1:0] z_in,
  input  logic flip_in,
  input  evg_pkg::side_t side_in,
  output logic signed [evg_pkg::CordW-1:0] x_out,
  output logic signed [evg_pkg::CordW-1:0] y_out,
  output logic signed [evg_pkg::AngW-1:0] z_out,
  output logic flip_out,
  output evg_pkg::side_t side_out
);
  import evg_pkg::*;
  logic signed [CordW-1:0] dx;
  logic signed [CordW-1:0] dy;
  logic signed [AngW-1:0] at;
  always_comb begin
    dx = y_in >>> stage;
    dy = x_in >>> stage;
    at = $signed({1'b0, atan_turn(int'(stage))});
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[AngW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end
      flip_out <= flip_in;
      side_out <= side_in;
    end
  end
endmodule

/* rtl/core/ellipse_vertex_generator.sv */
// Ellipse vertex generator: one polyline vertex per input transaction.
// Input channel: in_valid/in_stall with vertex_index. Output channel:
// out_valid/out_stall with point_x, point_y, point_color and is_last.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data while the block is idle; the user must keep to this, as the
// block does not enforce it. cfg_ready is always high. The datapath is a
// row of cells: 45 restoring divider cells form the phase, one fold cell,
// 16 CORDIC cells, then two multiply stages and a saturating add. One
// transaction can be taken each cycle while in_stall is low; throughput is
// one vertex per cycle while the output is not stalled. When out_stall and
// out_valid are both high the whole row holds and in_stall rises, so no
// transaction is lost. Reset clears all valid bits and loads the register
// defaults: radius 1.0, unit scales, zero center, 64 segments, white color.
module ellipse_vertex_generator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [12:0] vertex_index,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [23:0] point_x,
  output logic signed [23:0] point_y,
  output logic [31:0] point_color,
  output logic is_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import evg_pkg::*;
  localparam int Depth = DivSteps + 1 + CordicStages + 3;

  logic [15:0] radius;
  logic [15:0] scale_x;
  logic [15:0] scale_y;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [SegW-1:0] segments;
  logic [31:0] vertex_color;
  logic [Depth-1:0] vld;
  logic en;
  logic [SegW-1:0] seg_eff;
  side_t side0;

  assign cfg_ready = 1'b1;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd16;
      scale_x <= 16'd4096;
      scale_y <= 16'd4096;
      center_x <= '0;
      center_y <= '0;
      segments <= 13'd64;
      vertex_color <= 32'hFFFFFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS: radius <= cfg_data[15:0];
        REG_SCALE_X: scale_x <= cfg_data[15:0];
        REG_SCALE_Y: scale_y <= cfg_data[15:0];
        REG_CENTER_X: center_x <= cfg_data[23:0];
        REG_CENTER_Y: center_y <= cfg_data[23:0];
        REG_SEGMENTS: segments <= cfg_data[12:0];
        REG_COLOR: vertex_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_valid};
  end

  always_comb begin
    if (segments == '0) seg_eff = SegW'(1);
    else if (segments > SegW'(MaxSegments)) seg_eff = SegW'(MaxSegments);
    else seg_eff = segments;
    side0.last = (vertex_index == seg_eff);
    side0.color = vertex_color;
    side0.radius = radius;
    side0.scale_x = scale_x;
    side0.scale_y = scale_y;
    side0.center_x = center_x;
    side0.center_y = center_y;
  end

  // Divider row: numerator idx*2^32 + seg/2, quotient low 32 bits used.
  logic [QuoW-1:0] dnum [DivSteps+1];
  logic [SegW:0] drem [DivSteps+1];
  logic [SegW-1:0] dseg [DivSteps+1];
  side_t dside [DivSteps+1];
  logic [QuoW-1:0] num0;
  always_comb begin
    num0 = {vertex_index, 32'd0} + QuoW'(seg_eff >> 1);
  end
  assign dnum[0] = num0;
  assign drem[0] = '0;
  assign dseg[0] = seg_eff;
  assign dside[0] = side0;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    evg_div_cell u_cell (
      .clk(clk), .en(en), .num_in(dnum[g]), .rem_in(drem[g]), .seg_in(dseg[g]),
      .side_in(dside[g]), .num_out(dnum[g+1]), .rem_out(drem[g+1]),
      .seg_out(dseg[g+1]), .side_out(dside[g+1])
    );
  end

  // Fold cell.
  logic signed [AngW-1:0] cz [CordicStages+1];
  logic signed [CordW-1:0] cx [CordicStages+1];
  logic signed [CordW-1:0] cy [CordicStages+1];
  logic cflip [CordicStages+1];
  side_t cside [CordicStages+1];
  logic signed [AngW-1:0] ang;
  always_comb begin
    ang = $signed({dnum[DivSteps][31], dnum[DivSteps][31:0]});
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (ang > $signed(AngW'(1073741824))) begin
        cz[0] <= ang - $signed(AngW'(33'sh80000000));
        cflip[0] <= 1'b1;
      end else if (ang < -$signed(AngW'(1073741824))) begin
        cz[0] <= ang + $signed(AngW'(33'sh80000000));
        cflip[0] <= 1'b1;
      end else begin
        cz[0] <= ang;
        cflip[0] <= 1'b0;
      end
      cx[0] <= InvGain;
      cy[0] <= '0;
      cside[0] <= dside[DivSteps];
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    evg_cordic_cell u_cell (
      .clk(clk), .en(en), .stage(5'(g)), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .flip_in(cflip[g]), .side_in(cside[g]), .x_out(cx[g+1]), .y_out(cy[g+1]),
      .z_out(cz[g+1]), .flip_out(cflip[g+1]), .side_out(cside[g+1])
    );
  end

  // Rounding to Q.16 and magnitude products.
  logic signed [CordW-1:0] fx;
  logic signed [CordW-1:0] fy;
  logic signed [CordW-1:0] rx;
  logic signed [CordW-1:0] ry;
  logic signed [18:0] c16;
  logic signed [18:0] s16;
  logic [31:0] mx;
  logic [31:0] my;
  side_t s1;
  always_comb begin
    fx = cflip[CordicStages] ? -cx[CordicStages] : cx[CordicStages];
    fy = cflip[CordicStages] ? -cy[CordicStages] : cy[CordicStages];
    rx = (fx + CordW'(8192)) >>> 14;
    ry = (fy + CordW'(8192)) >>> 14;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c16 <= rx[18:0];
      s16 <= ry[18:0];
      mx <= cside[CordicStages].radius * cside[CordicStages].scale_x;
      my <= cside[CordicStages].radius * cside[CordicStages].scale_y;
      s1 <= cside[CordicStages];
    end
  end

  logic signed [51:0] px;
  logic signed [51:0] py;
  side_t s2;
  always_ff @(posedge clk) begin
    if (en) begin
      px <= $signed({1'b0, mx}) * c16 + 52'sd8388608;
      py <= $signed({1'b0, my}) * s16 + 52'sd8388608;
      s2 <= s1;
    end
  end

  logic signed [28:0] tx;
  logic signed [28:0] ty;
  always_comb begin
    tx = 29'(px >>> 24) + 29'(s2.center_x);
    ty = 29'(py >>> 24) + 29'(s2.center_y);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (tx > 29'sd8388607) point_x <= 24'sh7FFFFF;
      else if (tx < -29'sd8388608) point_x <= 24'sh800000;
      else point_x <= tx[23:0];
      if (ty > 29'sd8388607) point_y <= 24'sh7FFFFF;
      else if (ty < -29'sd8388608) point_y <= 24'sh800000;
      else point_y <= ty[23:0];
      point_color <= s2.color;
      is_last <= s2.last;
    end
  end
  assign out_valid = vld[Depth-1];

  `include "ellipse_vertex_generator_assert.svh"
  `EVG_ASSERT_IMPL(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(point_x), "output changed while stalled")
  `EVG_ASSERT_IMPL(a_stall, clk, rst, in_stall == (out_valid && out_stall), "input stall mismatch")
  `EVG_ASSERT_NR(a_reset, clk, $past(rst) |-> !out_valid, "valid after reset")
  `EVG_ASSERT_IMPL(a_move, clk, rst, !$past(rst) && !$past(in_stall) |-> vld[0] == $past(in_valid), "pipe entry mismatch")
endmodule
